// ===== hdl/bch_31_21_encode_correct_core_defines.svh =====
// ----------------------------------------------------------------------------
// BCH(31,21) core assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef BCH_31_21_ENCODE_CORRECT_CORE_DEFINES_SVH
`define BCH_31_21_ENCODE_CORRECT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// BCH(31,21) core package
// Constants, error syndrome table and the control/status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bce_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned SynW     = 10;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CrcSteps = 21;
  localparam int unsigned MegSteps = 31;

  // Generator 0x769 without its leading term.
  localparam logic [SynW-1:0] GenLow  = 10'h369;
  // Syndrome of an error in the leading bit.
  localparam logic [SynW-1:0] SynFlip = 10'h3B4;

  typedef logic [SynW-1:0] syn_t;

  localparam syn_t ErrSyn [MegSteps] = '{
    10'h3B4, 10'h26E, 10'h359, 10'h076, 10'h255, 10'h0F0, 10'h216, 10'h365,
    10'h068, 10'h25A, 10'h343, 10'h07B, 10'h1E7, 10'h129, 10'h14E, 10'h2C9,
    10'h0BE, 10'h231, 10'h0C2, 10'h20F, 10'h0DD, 10'h1B4, 10'h2B4, 10'h334,
    10'h3F4, 10'h394, 10'h3A4, 10'h3BC, 10'h3B0, 10'h3B6, 10'h3B5
  };

  typedef enum logic [1:0] {
    RES_ENC,
    RES_WORD_OK,
    RES_WORD_FAIL,
    RES_ACC
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     crc_step;
    logic     synd_eval;
    logic     meg_step;
    logic     res_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic op_repair;
    logic syn_zero;
    logic meg_fail;
    logic meg_syn_clear;
  } sts_t;

  // True when the syndrome matches an error pattern with the leading bit set.
  function automatic logic is_err_syndrome(input syn_t s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MegSteps; i++) begin
      hit = hit | (s == ErrSyn[i]);
    end
    return hit;
  endfunction

  // One shift of the syndrome register, reducing by the generator.
  function automatic syn_t syn_shift(input syn_t s);
    return {s[SynW-2:0], 1'b0} ^ (s[SynW-1] ? GenLow : '0);
  endfunction

endpackage

// ===== hdl/bce_ctrl.sv =====
// ----------------------------------------------------------------------------
// BCH(31,21) controller
// Sequences check-bit generation, syndrome evaluation and the Meggitt steps,
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bch_31_21_encode_correct_core_defines.svh"

module bce_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  bce_pkg::sts_t sts_i,
  output bce_pkg::cmd_t cmd_o
);
  import bce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_SYND,
    ST_MEG
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '{load: 1'b0, crc_step: 1'b0, synd_eval: 1'b0, meg_step: 1'b0,
                res_load: 1'b0, res_sel: RES_ENC};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(CrcSteps - 1)) begin
          state_d = ST_SYND;
        end
      end
      ST_SYND: begin
        if (!sts_i.op_repair) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_ENC;
            state_d        = ST_IDLE;
          end
        end else if (sts_i.syn_zero) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_WORD_OK;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.synd_eval = 1'b1;
          cnt_d           = '0;
          state_d         = ST_MEG;
        end
      end
      ST_MEG: begin
        if (sts_i.meg_fail) begin
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_WORD_FAIL;
            state_d        = ST_IDLE;
          end
        end else if (cnt_q == CntW'(MegSteps - 1)) begin
          // The last step decides between the corrected word and a failure.
          if (out_free) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = sts_i.meg_syn_clear ? RES_ACC : RES_WORD_FAIL;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.meg_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `BCE_ASSERT_SAME(a_res_no_overwrite, cmd_o.res_load, !out_valid_q || out_ready_i)
  `BCE_ASSERT_SAME(a_one_dp_cmd, 1'b1,
                   $onehot0({cmd_o.load, cmd_o.crc_step, cmd_o.synd_eval, cmd_o.meg_step}))
  `BCE_ASSERT_NEXT(a_accept_starts_crc, in_valid_i && in_ready_o,
                   state_q == ST_CRC && cnt_q == '0 && !in_ready_o)

endmodule

// ===== hdl/bce_dpath.sv =====
// ----------------------------------------------------------------------------
// BCH(31,21) datapath
// Serial check-bit register, syndrome and parity evaluation, the Meggitt
// correction step and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bce_dpath (
  input  logic                       clk_i,
  input  bce_pkg::cmd_t              cmd_i,
  output bce_pkg::sts_t              sts_o,
  input  logic                       op_i,
  input  logic [bce_pkg::WordW-1:0]  word_i,
  output logic [bce_pkg::WordW-1:0]  res_word_o,
  output logic                       res_sts_o
);
  import bce_pkg::*;

  logic [WordW-1:0] word_q;
  logic             op_q;
  logic [WordW-1:0] sh_q;
  syn_t             crc_q;
  syn_t             syn_q;
  logic             pmis_q;
  logic [WordW-1:0] acc_q;
  logic [1:0]       fixes_q;
  logic [WordW-1:0] res_word_q;
  logic             res_sts_q;

  logic             crc_fb;
  syn_t             crc_next;
  logic             enc_par;
  logic [WordW-1:0] enc_word;
  syn_t             syn_now;
  logic             pmis_now;
  logic             hit;
  syn_t             syn_fix;
  syn_t             syn_next;
  logic [1:0]       fixes_next;
  logic             fail;
  logic [WordW-1:0] acc_next;

  // Check bits are formed by feeding data bits 31..11 in from the top.
  assign crc_fb   = crc_q[SynW-1] ^ sh_q[WordW-1];
  assign crc_next = {crc_q[SynW-2:0], 1'b0} ^ (crc_fb ? GenLow : '0);

  assign enc_par  = ^{word_q[WordW-1:SynW+1], crc_q};
  assign enc_word = {word_q[WordW-1:SynW+1], crc_q, enc_par};
  assign syn_now  = crc_q ^ word_q[SynW:1];
  assign pmis_now = enc_par ^ word_q[0];

  assign hit        = is_err_syndrome(syn_q);
  assign syn_fix    = hit ? (syn_q ^ SynFlip) : syn_q;
  assign syn_next   = syn_shift(syn_fix);
  assign fixes_next = fixes_q + {1'b0, hit};
  // With a parity mismatch only one correction is allowed, otherwise two.
  assign fail       = hit && (pmis_q ? (fixes_next >= 2'd2) : (fixes_next == 2'd3));
  assign acc_next   = {acc_q[WordW-2:0], 1'b0}
                    | {{(WordW-2){1'b0}}, sh_q[WordW-1] ^ hit, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= word_i;
      op_q   <= op_i;
      sh_q   <= word_i;
      crc_q  <= '0;
    end
    if (cmd_i.crc_step) begin
      crc_q <= crc_next;
      sh_q  <= {sh_q[WordW-2:0], 1'b0};
    end
    if (cmd_i.synd_eval) begin
      syn_q   <= syn_now;
      pmis_q  <= pmis_now;
      sh_q    <= word_q;
      acc_q   <= '0;
      fixes_q <= '0;
    end
    if (cmd_i.meg_step) begin
      syn_q   <= syn_next;
      acc_q   <= acc_next;
      fixes_q <= fixes_next;
      sh_q    <= {sh_q[WordW-2:0], 1'b0};
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_ENC: begin
          res_word_q <= enc_word;
          res_sts_q  <= 1'b0;
        end
        RES_WORD_OK: begin
          res_word_q <= word_q;
          res_sts_q  <= 1'b0;
        end
        RES_WORD_FAIL: begin
          res_word_q <= word_q;
          res_sts_q  <= 1'b1;
        end
        RES_ACC: begin
          res_word_q <= acc_next;
          res_sts_q  <= 1'b0;
        end
        default: begin
          res_word_q <= word_q;
          res_sts_q  <= 1'b1;
        end
      endcase
    end
  end

  assign sts_o.op_repair     = op_q;
  assign sts_o.syn_zero      = (syn_now == '0);
  assign sts_o.meg_fail      = fail;
  assign sts_o.meg_syn_clear = (syn_next == '0);

  assign res_word_o = res_word_q;
  assign res_sts_o  = res_sts_q;

endmodule

// ===== hdl/bch_31_21_encode_correct_core.sv =====
// ----------------------------------------------------------------------------
// BCH(31,21) encode and repair core
// Encodes pager-style 32-bit words or corrects up to two bit errors in them.
// ----------------------------------------------------------------------------
// One word is worked on at a time. After a transaction is taken, the ten check
// bits are built serially, one data bit per cycle, and the cycle after that
// forms the syndrome. An encode, or a repair with a clean syndrome, has its
// result written to the output register from the syndrome step; any other
// repair then runs the Meggitt shift register, one codeword bit per cycle,
// before its result is written. A failed repair returns the input word with
// status set. The next input transaction can be taken in the cycle after the
// result has been written to the output register. A result still waiting in
// the output register delays that write, and with it the next input, until it
// has been taken.
`timescale 1ns / 1ps

module bch_31_21_encode_correct_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] codeword
  input  logic        s_axis_tuser,   // [0] operation (0 encode, 1 repair)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_word
  output logic        m_axis_tuser    // [0] status (1 uncorrectable)
);
  import bce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bce_dpath u_dpath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (s_axis_tuser),
    .word_i     (s_axis_tdata),
    .res_word_o (m_axis_tdata),
    .res_sts_o  (m_axis_tuser)
  );

endmodule
